// File: hdl/smmf_pkg.sv
// Shared types, constants and codes of the sliding median / mean filter.
`timescale 1ns / 1ps
package smmf_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int WIDTH_W         = 4;
    localparam int MAX_WINDOW      = 15;
    localparam int IDX_W           = 4;
    localparam int FLUSH_W         = 3;
    localparam int SUM_W           = 20;
    localparam int MAG_W           = 19;
    localparam int DIV_STEPS       = 19;
    localparam int STEP_W          = 5;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 4;

    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 4'd3;
    localparam logic               MODE_RESET  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_WIDTH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_MODE  = 1'b1;

    // Filter mode codes
    localparam logic MODE_MEAN   = 1'b0;
    localparam logic MODE_MEDIAN = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // What the back part does with one item besides any flush
    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_PASS,
        JOB_CALC
    } job_kind_t;

    typedef struct packed {
        sample_t              sample;
        logic                 last;
        job_kind_t            kind;
        logic [FLUSH_W-1:0]   flush_cnt;
        logic [WIDTH_W-1:0]   width;
        logic                 mode;
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_RANK,
        B_SUM,
        B_DIV,
        B_EMIT,
        B_FLUSH
    } back_state_t;

endpackage

// File: hdl/smmf_in_if.sv
// Sample request channel: valid / ready with sample and end-of-record flag.
`timescale 1ns / 1ps
interface smmf_in_if
    import smmf_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    is_last;

    modport source (output valid, output sample, output is_last, input ready);
    modport sink   (input valid, input sample, input is_last, output ready);
    modport mon    (input valid, input sample, input is_last, input ready);
endinterface

// File: hdl/smmf_out_if.sv
// Result request channel: valid / ready with filtered value and end-of-record flag.
`timescale 1ns / 1ps
interface smmf_out_if
    import smmf_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t value;
    logic    last_out;

    modport source (output valid, output value, output last_out, input ready);
    modport sink   (input valid, input value, input last_out, output ready);
    modport mon    (input valid, input value, input last_out, input ready);
endinterface

// File: hdl/smmf_front.sv
// Front part: configuration registers, record sample count and job classification.
`timescale 1ns / 1ps
module smmf_front
    import smmf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    smmf_in_if.sink                in_ch,
    input  logic                   q_full,
    output logic                   q_push,
    output job_t                   q_job
);

    logic [WIDTH_W-1:0] width_reg;
    logic               mode_reg;
    logic [3:0]         count_reg;
    logic [3:0]         count_next;
    logic [2:0]         half;
    logic [3:0]         half_x;
    logic [3:0]         twice_half;
    logic [3:0]         k_minus_h;
    logic               below_half;
    logic               full_window;

    // Accept while the queue has room
    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;

    assign half        = width_reg[3:1];
    assign half_x      = {1'b0, half};
    assign twice_half  = {half, 1'b0};
    assign below_half  = count_reg < half_x;
    assign full_window = count_reg >= twice_half;
    assign k_minus_h   = count_reg - half_x;

    // Classify the request against the current count
    always_comb
    begin
        q_job.sample    = in_ch.sample;
        q_job.last      = in_ch.is_last;
        q_job.width     = width_reg;
        q_job.mode      = mode_reg;
        q_job.kind      = JOB_NONE;
        q_job.flush_cnt = '0;
        if (!width_reg[0])
        begin
            q_job.kind = JOB_PASS;
        end
        else if (below_half)
        begin
            q_job.kind = JOB_PASS;
        end
        else if (full_window)
        begin
            q_job.kind = JOB_CALC;
            if (in_ch.is_last)
                q_job.flush_cnt = half;
        end
        else
        begin
            if (in_ch.is_last)
                q_job.flush_cnt = FLUSH_W'(k_minus_h + 4'd1);
        end
    end

    // Count samples of the record, saturating; clear after the last one
    always_comb
    begin
        count_next = count_reg;
        if (q_push)
        begin
            if (in_ch.is_last)
                count_next = '0;
            else if (count_reg != 4'hF)
                count_next = count_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
            mode_reg  <= MODE_RESET;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_WIDTH: width_reg <= cfg_data[WIDTH_W-1:0];
                    CFG_FILTER_MODE:  mode_reg  <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

endmodule

// File: hdl/smmf_queue.sv
// Short job queue between the front and back parts.
`timescale 1ns / 1ps
module smmf_queue
    import smmf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = cnt_reg == CNT_FULL;
    assign pop_valid = cnt_reg != '0;
    assign pop_job   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Write the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    // Advance pointers and the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// File: hdl/smmf_back.sv
// Back part: sample window, rank median, serial mean with divide, result register.
`timescale 1ns / 1ps
module smmf_back
    import smmf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         q_valid,
    input  job_t         q_job,
    output logic         q_pop,
    smmf_out_if.source   out_ch
);

    back_state_t          state_reg;
    back_state_t          state_next;
    job_t                 job_reg;
    logic [SAMPLE_W-1:0]  store_reg [MAX_WINDOW];
    logic [IDX_W-1:0]     idx_reg;
    logic signed [SUM_W-1:0] acc_reg;
    logic [MAG_W-1:0]     quo_reg;
    logic [3:0]           rem_reg;
    logic                 neg_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [SAMPLE_W-1:0]  res_reg;
    logic                 out_valid_reg;
    logic [SAMPLE_W-1:0]  out_value_reg;
    logic                 out_last_reg;

    logic [SAMPLE_W-1:0]  rd_data;
    logic [IDX_W-1:0]     rank;
    logic                 rank_hit;
    logic signed [SUM_W-1:0] acc_next;
    logic                 sum_done;
    logic [MAG_W-1:0]     mag;
    logic [4:0]           rem_shift;
    logic                 rem_ge;
    logic [3:0]           rem_next;
    logic [MAG_W-1:0]     quo_next;
    logic [SAMPLE_W-1:0]  quo16;
    logic                 div_done;
    logic                 slot_free;
    logic                 emit_main;
    logic                 emit_flush;
    logic [FLUSH_W-1:0]   pop_flush_m1;
    logic [FLUSH_W-1:0]   job_flush_m1;

    assign rd_data      = store_reg[idx_reg];
    assign slot_free    = !out_valid_reg || out_ch.ready;
    assign pop_flush_m1 = q_job.flush_cnt - 1'b1;
    assign job_flush_m1 = job_reg.flush_cnt - 1'b1;

    // Rank of the candidate: smaller entries, and equal ones at lower index
    always_comb
    begin
        logic lt;
        logic eq;
        rank = '0;
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            lt = $signed(store_reg[j]) < $signed(rd_data);
            eq = (store_reg[j] == rd_data) && (IDX_W'(j) < idx_reg);
            if ((IDX_W'(j) < job_reg.width) && (lt || eq))
                rank = rank + 1'b1;
        end
    end
    assign rank_hit = rank == {1'b0, job_reg.width[3:1]};

    // Serial sum, one entry per cycle
    assign acc_next = acc_reg + SUM_W'($signed(rd_data));
    assign sum_done = idx_reg == (job_reg.width - 1'b1);
    assign mag      = acc_next[SUM_W-1] ? MAG_W'(-acc_next) : acc_next[MAG_W-1:0];

    // One restoring divide step per cycle
    assign rem_shift = {rem_reg, quo_reg[MAG_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, job_reg.width};
    assign rem_next  = rem_ge ? 4'(rem_shift - {1'b0, job_reg.width}) : rem_shift[3:0];
    assign quo_next  = {quo_reg[MAG_W-2:0], rem_ge};
    assign quo16     = quo_next[SAMPLE_W-1:0];
    assign div_done  = step_reg == '0;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_job.kind == JOB_CALC)
                        state_next = (q_job.mode == MODE_MEDIAN) ? B_RANK : B_SUM;
                    else if (q_job.kind == JOB_PASS)
                        state_next = B_EMIT;
                    else if (q_job.flush_cnt != '0)
                        state_next = B_FLUSH;
                end
            end
            B_RANK:
            begin
                if (rank_hit)
                    state_next = B_EMIT;
            end
            B_SUM:
            begin
                if (sum_done)
                    state_next = B_DIV;
            end
            B_DIV:
            begin
                if (div_done)
                    state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (slot_free)
                    state_next = (job_reg.flush_cnt != '0) ? B_FLUSH : B_IDLE;
            end
            B_FLUSH:
            begin
                if (slot_free && idx_reg == '0)
                    state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        q_pop      = 1'b0;
        emit_main  = 1'b0;
        emit_flush = 1'b0;
        unique case (state_reg)
            B_IDLE:  q_pop      = q_valid;
            B_EMIT:  emit_main  = slot_free;
            B_FLUSH: emit_flush = slot_free;
            default: ;
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg      <= q_job;
            store_reg[0] <= q_job.sample;
            for (int i = 1; i < MAX_WINDOW; i++)
                store_reg[i] <= store_reg[i-1];
            acc_reg <= '0;
            res_reg <= q_job.sample;
            idx_reg <= (q_job.kind == JOB_NONE) ? IDX_W'(pop_flush_m1) : '0;
        end
        unique case (state_reg)
            B_RANK:
            begin
                if (rank_hit)
                    res_reg <= rd_data;
                else
                    idx_reg <= idx_reg + 1'b1;
            end
            B_SUM:
            begin
                acc_reg <= acc_next;
                idx_reg <= idx_reg + 1'b1;
                if (sum_done)
                begin
                    neg_reg  <= acc_next[SUM_W-1];
                    quo_reg  <= mag;
                    rem_reg  <= '0;
                    step_reg <= STEP_W'(DIV_STEPS - 1);
                end
            end
            B_DIV:
            begin
                quo_reg  <= quo_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg - 1'b1;
                if (div_done)
                    res_reg <= neg_reg ? -quo16 : quo16;
            end
            B_EMIT:
            begin
                if (emit_main)
                    idx_reg <= IDX_W'(job_flush_m1);
            end
            B_FLUSH:
            begin
                if (emit_flush)
                    idx_reg <= idx_reg - 1'b1;
            end
            default: ;
        endcase
        // Load the result register
        if (emit_main)
        begin
            out_value_reg <= res_reg;
            out_last_reg  <= job_reg.last && (job_reg.flush_cnt == '0);
        end
        else if (emit_flush)
        begin
            out_value_reg <= rd_data;
            out_last_reg  <= idx_reg == '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_main || emit_flush)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.value    = out_value_reg;
    assign out_ch.last_out = out_last_reg;

endmodule

// File: hdl/sliding_median_mean_filter.sv
// Top level of the sliding median / mean filter.
//
// Samples (signed Q8.8) enter on sample_ch and results leave on result_ch,
// both valid / ready; a request moves when valid and ready are high at a clock
// edge. cfg_we writes window_width (index 0) or filter_mode (index 1) from
// cfg_data; write only while no request is in flight.
// The front classifies each sample against the record count and pushes a job
// into a short queue; the back shifts the sample into the window, computes
// and loads a one-entry result register.
// Steps per sample in the back: a sample with no output is only dequeued;
// a pass-through is dequeued, then loaded; median ranks the window entries,
// one candidate per cycle, then loads the result; mean adds the W entries
// serially, then runs a restoring divide, one quotient bit per cycle, then
// loads the result. At end of record each flushed sample is then emitted.
// When the back is busy, an accepted sample waits in the queue until the
// back has finished its earlier jobs.
// Reset clears the queue, count, state and result valid; the window store is
// not cleared. When the receiver stalls, the result holds, the back waits,
// the queue fills and sample_ch.ready drops.
`timescale 1ns / 1ps
module sliding_median_mean_filter
    import smmf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    smmf_in_if.sink                sample_ch,
    smmf_out_if.source             result_ch
);

    logic q_full;
    logic q_push;
    job_t push_job;
    logic q_pop;
    logic q_valid;
    job_t pop_job;

    smmf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (sample_ch),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    smmf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_job   (pop_job)
    );

    smmf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (pop_job),
        .q_pop   (q_pop),
        .out_ch  (result_ch)
    );

endmodule

// File: hdl/smmf_checker.sv
// Port-level checks of the filter, bound to the top level.
`timescale 1ns / 1ps
module smmf_checker
    import smmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    smmf_in_if.sink    sample_ch,
    smmf_out_if.source result_ch
);

    logic       in_last_acc;
    logic       out_last_acc;
    logic [7:0] open_last_reg;

    assign in_last_acc  = sample_ch.valid && sample_ch.ready && sample_ch.is_last;
    assign out_last_acc = result_ch.valid && result_ch.ready && result_ch.last_out;

    // Track records whose closing result is still owed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_last_reg <= '0;
        else if (in_last_acc && !out_last_acc)
            open_last_reg <= open_last_reg + 1'b1;
        else if (out_last_acc && !in_last_acc)
            open_last_reg <= open_last_reg - 1'b1;
    end

    // Hold a stalled result request
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && !result_ch.ready |=> result_ch.valid)
        else $error("result valid dropped while stalled");

    // Hold the stalled payload
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && !result_ch.ready |=>
            $stable(result_ch.value) && $stable(result_ch.last_out))
        else $error("result payload changed while stalled");

    // Reset leaves no result pending
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !result_ch.valid)
        else $error("result valid after reset");

    // A record end on the result side needs an accepted last sample
    a_last_owed: assert property (@(posedge clk) disable iff (!rst_n)
        out_last_acc |-> (open_last_reg != '0) || in_last_acc)
        else $error("last_out without a matching last sample");

endmodule

bind sliding_median_mean_filter smmf_checker u_smmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
);
